@@ rtl/assert_macros.svh @@
// Assertion helpers used by the checker.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed in %m");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed in %m");

`endif

@@ rtl/m4i_pkg.sv @@
// ----------------------------------------------------------------------------
// m4i_pkg
// Shared types, widths and permutation tables of the 4x4 matrix inverse core.
// ----------------------------------------------------------------------------
package m4i_pkg;

   localparam int MATRIX_DIM = 4;
   localparam int CELLS      = MATRIX_DIM * MATRIX_DIM;
   localparam int IDX_W      = $clog2(CELLS);
   localparam int FRAC_BITS  = 16;
   localparam int DATA_W     = 32;
   localparam int WIDE_W     = 64;
   localparam int PROD_W     = 2 * WIDE_W;
   localparam int DIV_STEPS  = WIDE_W + FRAC_BITS;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
   localparam int TERMS4     = 24;
   localparam int TERMS3     = 6;

   localparam logic [WIDE_W-1:0] WIDE_MAX = {1'b0, {(WIDE_W-1){1'b1}}};
   localparam logic [WIDE_W-1:0] WIDE_MIN = {1'b1, {(WIDE_W-1){1'b0}}};
   localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef logic [CELLS-1:0][DATA_W-1:0] matrix_type;

   typedef struct packed {
      logic                     start;
      logic signed [WIDE_W-1:0] num;
      logic signed [WIDE_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] value;
      logic              clip;
   } div_rsp_type;

   // Column position chosen at row d sits in bits [2d+1:2d]; terms are in
   // lexicographic order of the chosen positions.
   localparam logic [TERMS4-1:0][7:0] PERM4 = {
      8'h1B, 8'h4B, 8'h27, 8'h87, 8'h63, 8'h93,
      8'h1E, 8'h4E, 8'h36, 8'hC6, 8'h72, 8'hD2,
      8'h2D, 8'h8D, 8'h39, 8'hC9, 8'hB1, 8'hE1,
      8'h6C, 8'h9C, 8'h78, 8'hD8, 8'hB4, 8'hE4};
   localparam logic [TERMS4-1:0] PERM4_ODD = 24'h666666;

   localparam logic [TERMS3-1:0][7:0] PERM3 = {
      8'h06, 8'h12, 8'h09, 8'h21, 8'h18, 8'h24};
   localparam logic [TERMS3-1:0] PERM3_ODD = 6'b100110;

endpackage

@@ rtl/m4i_front.sv @@
// ----------------------------------------------------------------------------
// m4i_front
// Entry loader: keeps the matrix and queues a snapshot when the last entry
// arrives.
// ----------------------------------------------------------------------------
module m4i_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [m4i_pkg::IDX_W-1:0]     entry_index,
   input  logic [m4i_pkg::DATA_W-1:0]    entry_value,
   input  logic                          q_full,
   output logic                          q_push,
   output m4i_pkg::matrix_type           q_data
);

   m4i_pkg::matrix_type store_ff;
   m4i_pkg::matrix_type store_in;
   logic                accept;

   assign busy   = q_full;
   assign accept = start && !q_full;

   always_comb begin
      store_in = store_ff;
      if (accept) begin
         store_in[entry_index] = entry_value;
      end
   end

   // The snapshot already holds the entry of this transaction.
   assign q_push = accept && (entry_index == m4i_pkg::IDX_W'(m4i_pkg::CELLS - 1));
   assign q_data = store_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff <= '0;
      end else begin
         store_ff <= store_in;
      end
   end

endmodule

@@ rtl/m4i_queue.sv @@
// ----------------------------------------------------------------------------
// m4i_queue
// Two-entry queue of matrix snapshots between the loader and the engine.
// ----------------------------------------------------------------------------
module m4i_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  m4i_pkg::matrix_type push_data,
   output logic                full,
   input  logic                pop,
   output m4i_pkg::matrix_type pop_data,
   output logic                empty
);

   m4i_pkg::matrix_type slot_ff [2];
   logic                wr_ff, wr_in;
   logic                rd_ff, rd_in;
   logic [1:0]          count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = slot_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push && !full) begin
         wr_in = !wr_ff;
      end
      if (pop && !empty) begin
         rd_in = !rd_ff;
      end
      if ((push && !full) && !(pop && !empty)) begin
         count_in = count_ff + 2'd1;
      end else if (!(push && !full) && (pop && !empty)) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ rtl/m4i_div.sv @@
// ----------------------------------------------------------------------------
// m4i_div
// Restoring divider, one quotient bit per cycle, giving the saturated
// Q16.16 quotient of a scaled 64-bit numerator by a 64-bit denominator.
// ----------------------------------------------------------------------------
module m4i_div (
   input  logic                 clock,
   input  logic                 reset,
   input  m4i_pkg::div_req_type req,
   output m4i_pkg::div_rsp_type rsp
);

   localparam int DVD_W = m4i_pkg::DIV_STEPS;
   localparam int W     = m4i_pkg::WIDE_W;

   logic                              run_ff, run_in;
   logic                              fin_ff, fin_in;
   logic                              done_ff, done_in;
   logic [m4i_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DVD_W-1:0]                  dvd_ff, dvd_in;
   logic [W-1:0]                      den_ff, den_in;
   logic [W-1:0]                      rem_ff, rem_in;
   logic [W-1:0]                      q_ff, q_in;
   logic                              over_ff, over_in;
   logic                              neg_ff, neg_in;
   logic [m4i_pkg::DATA_W-1:0]        value_ff, value_in;
   logic                              clip_ff, clip_in;
   logic [W:0]                        rem_wide;
   logic [W-1:0]                      num_mag;
   logic [W-1:0]                      den_mag;
   logic [W-1:0]                      limit;

   assign num_mag  = req.num[W-1] ? (~req.num + 1'b1) : req.num;
   assign den_mag  = req.den[W-1] ? (~req.den + 1'b1) : req.den;
   assign rem_wide = {rem_ff, dvd_ff[DVD_W-1]};
   assign limit    = neg_ff ? W'({1'b1, {(m4i_pkg::DATA_W-1){1'b0}}})
                            : W'(m4i_pkg::DATA_MAX);

   always_comb begin
      run_in   = run_ff;
      fin_in   = 1'b0;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      dvd_in   = dvd_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      over_in  = over_ff;
      neg_in   = neg_ff;
      value_in = value_ff;
      clip_in  = clip_ff;
      if (req.start && !run_ff && !fin_ff) begin
         run_in  = 1'b1;
         cnt_in  = '0;
         dvd_in  = {num_mag, {m4i_pkg::FRAC_BITS{1'b0}}};
         den_in  = den_mag;
         rem_in  = '0;
         q_in    = '0;
         over_in = 1'b0;
         neg_in  = req.num[W-1] ^ req.den[W-1];
      end else if (run_ff) begin
         dvd_in  = dvd_ff << 1;
         over_in = over_ff | q_ff[W-1];
         if (rem_wide >= {1'b0, den_ff}) begin
            rem_in = W'(rem_wide - {1'b0, den_ff});
            q_in   = {q_ff[W-2:0], 1'b1};
         end else begin
            rem_in = rem_wide[W-1:0];
            q_in   = {q_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == m4i_pkg::DIV_CNT_W'(DVD_W - 1)) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end else if (fin_ff) begin
         done_in = 1'b1;
         if (over_ff || (q_ff > limit)) begin
            clip_in  = 1'b1;
            value_in = neg_ff ? m4i_pkg::DATA_MIN : m4i_pkg::DATA_MAX;
         end else begin
            clip_in  = 1'b0;
            value_in = neg_ff ? (~q_ff[m4i_pkg::DATA_W-1:0] + 1'b1)
                              : q_ff[m4i_pkg::DATA_W-1:0];
         end
      end
   end

   assign rsp.done  = done_ff;
   assign rsp.value = value_ff;
   assign rsp.clip  = clip_ff;

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      dvd_ff   <= dvd_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      q_ff     <= q_in;
      over_ff  <= over_in;
      neg_ff   <= neg_in;
      value_ff <= value_in;
      clip_ff  <= clip_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
   end

endmodule

@@ rtl/m4i_back.sv @@
// ----------------------------------------------------------------------------
// m4i_back
// Compute engine: determinant and cofactors by permutation expansion on one
// shared multiplier, then one division per inverse entry.
// ----------------------------------------------------------------------------
module m4i_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   output logic                          q_pop,
   input  m4i_pkg::matrix_type           q_data,
   output m4i_pkg::div_req_type          div_req,
   input  m4i_pkg::div_rsp_type          div_rsp,
   output logic                          rsp_valid,
   output logic [m4i_pkg::IDX_W-1:0]     rsp_out_index,
   output logic [m4i_pkg::DATA_W-1:0]    rsp_out_value,
   output logic [m4i_pkg::DATA_W-1:0]    rsp_determinant,
   output logic                          rsp_singular,
   output logic                          rsp_saturated,
   output logic                          rsp_last
);

   localparam int W  = m4i_pkg::WIDE_W;
   localparam int PW = m4i_pkg::PROD_W;
   localparam int DW = m4i_pkg::DATA_W;
   localparam int HW = W / 2;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FETCH = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_MFIN  = 3'd3;
   localparam logic [2:0] ST_ACC   = 3'd4;
   localparam logic [2:0] ST_XEND  = 3'd5;
   localparam logic [2:0] ST_DIV   = 3'd6;

   function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
      logic [W:0] s;
      begin
         s = {a[W-1], a} + {b[W-1], b};
         if (s[W] != s[W-1]) begin
            return s[W] ? m4i_pkg::WIDE_MIN : m4i_pkg::WIDE_MAX;
         end
         return s[W-1:0];
      end
   endfunction

   function automatic logic [W-1:0] sat_sub(input logic [W-1:0] a, input logic [W-1:0] b);
      logic [W:0] s;
      begin
         s = {a[W-1], a} - {b[W-1], b};
         if (s[W] != s[W-1]) begin
            return s[W] ? m4i_pkg::WIDE_MIN : m4i_pkg::WIDE_MAX;
         end
         return s[W-1:0];
      end
   endfunction

   logic [2:0]                    state_ff, state_in;
   logic                          det_mode_ff, det_mode_in;
   logic [4:0]                    term_ff, term_in;
   logic [1:0]                    depth_ff, depth_in;
   logic [m4i_pkg::IDX_W-1:0]     k_ff, k_in;
   logic [1:0]                    mcnt_ff, mcnt_in;
   m4i_pkg::matrix_type           work_ff, work_in;
   logic [W-1:0]                  prod_ff, prod_in;
   logic [W-1:0]                  acc_ff, acc_in;
   logic [W-1:0]                  det_ff, det_in;
   logic [W-1:0]                  mag_a_ff, mag_a_in;
   logic [W-1:0]                  mag_b_ff, mag_b_in;
   logic                          mneg_ff, mneg_in;
   logic [PW-1:0]                 macc_ff, macc_in;
   logic                          valid_ff, valid_in;
   logic [m4i_pkg::IDX_W-1:0]     oidx_ff, oidx_in;
   logic [DW-1:0]                 oval_ff, oval_in;
   logic [DW-1:0]                 odet_ff, odet_in;
   logic                          osing_ff, osing_in;
   logic                          osat_ff, osat_in;
   logic                          olast_ff, olast_in;

   logic [7:0]                    perm_code;
   logic [1:0]                    pos;
   logic [1:0]                    row;
   logic [1:0]                    col;
   logic [1:0]                    skip_r;
   logic [1:0]                    skip_c;
   logic [W-1:0]                  elem;
   logic [1:0]                    last_depth;
   logic                          last_term;
   logic                          term_odd;
   logic [HW-1:0]                 part_a;
   logic [HW-1:0]                 part_b;
   logic [W-1:0]                  part_p;
   logic [PW-1:0]                 addend;
   logic signed [PW-1:0]          signed_p;
   logic signed [PW-1:0]          shifted_p;
   logic                          prod_fits;
   logic [W-1:0]                  cof;
   logic                          det_clip;
   logic [DW-1:0]                 det32;

   // A cofactor for inverse position (i,j) drops row j and column i.
   assign skip_r     = k_ff[1:0];
   assign skip_c     = k_ff[3:2];
   assign perm_code  = det_mode_ff ? m4i_pkg::PERM4[term_ff] : m4i_pkg::PERM3[term_ff[2:0]];
   assign pos        = perm_code[{depth_ff, 1'b0} +: 2];
   assign row        = det_mode_ff ? depth_ff : depth_ff + 2'((depth_ff >= skip_r) ? 1 : 0);
   assign col        = det_mode_ff ? pos : pos + 2'((pos >= skip_c) ? 1 : 0);
   assign elem       = {{(W-DW){work_ff[{row, col}][DW-1]}}, work_ff[{row, col}]};
   assign last_depth = det_mode_ff ? 2'd3 : 2'd2;
   assign last_term  = det_mode_ff ? (term_ff == 5'(m4i_pkg::TERMS4 - 1))
                                   : (term_ff == 5'(m4i_pkg::TERMS3 - 1));
   assign term_odd   = det_mode_ff ? m4i_pkg::PERM4_ODD[term_ff]
                                   : m4i_pkg::PERM3_ODD[term_ff[2:0]];

   // Four 32x32 partial products of the magnitudes, one per cycle.
   assign part_a = mcnt_ff[0] ? mag_a_ff[W-1:HW] : mag_a_ff[HW-1:0];
   assign part_b = mcnt_ff[1] ? mag_b_ff[W-1:HW] : mag_b_ff[HW-1:0];
   assign part_p = part_a * part_b;

   always_comb begin
      case (mcnt_ff)
         2'd0:    addend = {{W{1'b0}}, part_p};
         2'd3:    addend = {part_p, {W{1'b0}}};
         default: addend = {{HW{1'b0}}, part_p, {HW{1'b0}}};
      endcase
   end

   assign signed_p  = mneg_ff ? $signed(~macc_ff + 1'b1) : $signed(macc_ff);
   assign shifted_p = signed_p >>> m4i_pkg::FRAC_BITS;
   assign prod_fits = (&shifted_p[PW-1:W-1]) || !(|shifted_p[PW-1:W-1]);

   assign cof      = (k_ff[2] ^ k_ff[0]) ? sat_sub('0, acc_ff) : acc_ff;
   assign det_clip = !((&det_ff[W-1:DW-1]) || !(|det_ff[W-1:DW-1]));
   assign det32    = det_clip ? (det_ff[W-1] ? m4i_pkg::DATA_MIN : m4i_pkg::DATA_MAX)
                              : det_ff[DW-1:0];

   assign q_pop         = (state_ff == ST_IDLE) && !q_empty;
   assign div_req.start = (state_ff == ST_XEND) && !det_mode_ff;
   assign div_req.num   = $signed(cof);
   assign div_req.den   = $signed(det_ff);

   always_comb begin
      state_in    = state_ff;
      det_mode_in = det_mode_ff;
      term_in     = term_ff;
      depth_in    = depth_ff;
      k_in        = k_ff;
      mcnt_in     = mcnt_ff;
      work_in     = work_ff;
      prod_in     = prod_ff;
      acc_in      = acc_ff;
      det_in      = det_ff;
      mag_a_in    = mag_a_ff;
      mag_b_in    = mag_b_ff;
      mneg_in     = mneg_ff;
      macc_in     = macc_ff;
      valid_in    = 1'b0;
      oidx_in     = oidx_ff;
      oval_in     = oval_ff;
      odet_in     = odet_ff;
      osing_in    = osing_ff;
      osat_in     = osat_ff;
      olast_in    = olast_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               work_in     = q_data;
               det_mode_in = 1'b1;
               term_in     = '0;
               depth_in    = '0;
               k_in        = '0;
               acc_in      = '0;
               state_in    = ST_FETCH;
            end
         end
         ST_FETCH: begin
            if (depth_ff == 2'd0) begin
               prod_in  = elem;
               depth_in = 2'd1;
            end else begin
               mag_a_in = prod_ff[W-1] ? (~prod_ff + 1'b1) : prod_ff;
               mag_b_in = elem[W-1] ? (~elem + 1'b1) : elem;
               mneg_in  = prod_ff[W-1] ^ elem[W-1];
               macc_in  = '0;
               mcnt_in  = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            macc_in = macc_ff + addend;
            mcnt_in = mcnt_ff + 2'd1;
            if (mcnt_ff == 2'd3) begin
               state_in = ST_MFIN;
            end
         end
         ST_MFIN: begin
            if (prod_fits) begin
               prod_in = shifted_p[W-1:0];
            end else begin
               prod_in = signed_p[PW-1] ? m4i_pkg::WIDE_MIN : m4i_pkg::WIDE_MAX;
            end
            if (depth_ff == last_depth) begin
               state_in = ST_ACC;
            end else begin
               depth_in = depth_ff + 2'd1;
               state_in = ST_FETCH;
            end
         end
         ST_ACC: begin
            acc_in   = term_odd ? sat_sub(acc_ff, prod_ff) : sat_add(acc_ff, prod_ff);
            depth_in = '0;
            if (last_term) begin
               state_in = ST_XEND;
            end else begin
               term_in  = term_ff + 5'd1;
               state_in = ST_FETCH;
            end
         end
         ST_XEND: begin
            if (det_mode_ff) begin
               det_in = acc_ff;
               if (acc_ff == '0) begin
                  valid_in = 1'b1;
                  oidx_in  = '0;
                  oval_in  = '0;
                  odet_in  = '0;
                  osing_in = 1'b1;
                  osat_in  = 1'b0;
                  olast_in = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  det_mode_in = 1'b0;
                  k_in        = '0;
                  term_in     = '0;
                  acc_in      = '0;
                  state_in    = ST_FETCH;
               end
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               valid_in = 1'b1;
               oidx_in  = k_ff;
               oval_in  = div_rsp.value;
               odet_in  = det32;
               osing_in = 1'b0;
               osat_in  = div_rsp.clip || det_clip;
               olast_in = (k_ff == m4i_pkg::IDX_W'(m4i_pkg::CELLS - 1));
               if (k_ff == m4i_pkg::IDX_W'(m4i_pkg::CELLS - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  term_in  = '0;
                  acc_in   = '0;
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_index   = oidx_ff;
   assign rsp_out_value   = oval_ff;
   assign rsp_determinant = odet_ff;
   assign rsp_singular    = osing_ff;
   assign rsp_saturated   = osat_ff;
   assign rsp_last        = olast_ff;

   always_ff @(posedge clock) begin
      det_mode_ff <= det_mode_in;
      term_ff     <= term_in;
      depth_ff    <= depth_in;
      k_ff        <= k_in;
      mcnt_ff     <= mcnt_in;
      work_ff     <= work_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      mag_a_ff    <= mag_a_in;
      mag_b_ff    <= mag_b_in;
      mneg_ff     <= mneg_in;
      macc_ff     <= macc_in;
      oidx_ff     <= oidx_in;
      oval_ff     <= oval_in;
      odet_ff     <= odet_in;
      osing_ff    <= osing_in;
      osat_ff     <= osat_in;
      olast_ff    <= olast_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         det_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         det_ff   <= det_in;
         valid_ff <= valid_in;
      end
   end

endmodule

@@ rtl/matrix4_inverse_core.sv @@
// ----------------------------------------------------------------------------
// matrix4_inverse_core
// Inverse of a 4x4 signed Q16.16 matrix, loaded one entry per transaction.
// ----------------------------------------------------------------------------
// Entries are taken one per cycle whenever busy is low; a transaction with
// index 15 queues a snapshot of the whole matrix for the compute engine.
// busy rises only while two such snapshots are waiting. The engine works on
// one matrix at a time: 24 determinant terms and 16 cofactors of 6 terms each
// on a single multiplier that forms each product in a fetch, four 32x32
// partial products and a scaling step, then a divider that resolves one
// quotient bit per cycle for each inverse entry. A singular matrix ends its
// run with one result. Results appear as single-cycle rsp_valid strobes that
// never come back to back; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module matrix4_inverse_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [m4i_pkg::IDX_W-1:0]     req_entry_index,
   input  logic signed [m4i_pkg::DATA_W-1:0] req_entry_value,
   output logic                          rsp_valid,
   output logic [m4i_pkg::IDX_W-1:0]     rsp_out_index,
   output logic signed [m4i_pkg::DATA_W-1:0] rsp_out_value,
   output logic signed [m4i_pkg::DATA_W-1:0] rsp_determinant,
   output logic                          rsp_singular,
   output logic                          rsp_saturated,
   output logic                          rsp_last
);

   logic                  q_full;
   logic                  q_push;
   m4i_pkg::matrix_type   q_push_data;
   logic                  q_empty;
   logic                  q_pop;
   m4i_pkg::matrix_type   q_pop_data;
   m4i_pkg::div_req_type  div_req;
   m4i_pkg::div_rsp_type  div_rsp;
   logic [m4i_pkg::DATA_W-1:0] out_value;
   logic [m4i_pkg::DATA_W-1:0] out_det;

   m4i_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .entry_index (req_entry_index),
      .entry_value (req_entry_value),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (q_push_data)
   );

   m4i_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   m4i_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   m4i_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .q_data          (q_pop_data),
      .div_req         (div_req),
      .div_rsp         (div_rsp),
      .rsp_valid       (rsp_valid),
      .rsp_out_index   (rsp_out_index),
      .rsp_out_value   (out_value),
      .rsp_determinant (out_det),
      .rsp_singular    (rsp_singular),
      .rsp_saturated   (rsp_saturated),
      .rsp_last        (rsp_last)
   );

   assign rsp_out_value   = $signed(out_value);
   assign rsp_determinant = $signed(out_det);

endmodule

@@ rtl/m4i_checker.sv @@
// ----------------------------------------------------------------------------
// m4i_checker
// Port-level checks on the result stream of the matrix inverse core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module m4i_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic [m4i_pkg::IDX_W-1:0]     rsp_out_index,
   input logic [m4i_pkg::DATA_W-1:0]    rsp_out_value,
   input logic [m4i_pkg::DATA_W-1:0]    rsp_determinant,
   input logic                          rsp_singular,
   input logic                          rsp_saturated,
   input logic                          rsp_last
);

   // A singular run is a single, final result with everything else cleared.
   `ASSERT_SAME(a_singular_last, rsp_valid && rsp_singular, rsp_last)
   `ASSERT_SAME(a_singular_clear, rsp_valid && rsp_singular, (rsp_out_index == '0) && (rsp_out_value == '0) && (rsp_determinant == '0) && !rsp_saturated)
   // A regular result always carries a nonzero determinant.
   `ASSERT_SAME(a_det_nonzero, rsp_valid && !rsp_singular, rsp_determinant != '0)
   // The last regular result is the bottom-right inverse entry.
   `ASSERT_SAME(a_last_index, rsp_valid && !rsp_singular && rsp_last, rsp_out_index == m4i_pkg::IDX_W'(m4i_pkg::CELLS - 1))
   // Result strobes never come back to back.
   `ASSERT_NEXT(a_strobe_gap, rsp_valid, !rsp_valid)

endmodule

bind matrix4_inverse_core m4i_checker u_m4i_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_out_index   (rsp_out_index),
   .rsp_out_value   (rsp_out_value),
   .rsp_determinant (rsp_determinant),
   .rsp_singular    (rsp_singular),
   .rsp_saturated   (rsp_saturated),
   .rsp_last        (rsp_last)
);

@@ test/matrix4_inverse_core_tb.sv @@
// ----------------------------------------------------------------------------
// matrix4_inverse_core_tb
// Self-checking bench for the 4x4 Q16.16 matrix inverse core.
// ----------------------------------------------------------------------------
// Entries are loaded in bursts with random gaps. Every index-15 transaction
// makes the bench predict the determinant and the inverse of the loaded
// matrix, or the single singular response. Each strobed response is checked
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module matrix4_inverse_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 40000;
   localparam int DRAIN_CYCLES   = 400;
   localparam logic [m4i_pkg::IDX_W-1:0] LAST_INDEX = m4i_pkg::IDX_W'(m4i_pkg::CELLS - 1);

   typedef logic signed [m4i_pkg::WIDE_W-1:0] wide_type;
   typedef logic signed [m4i_pkg::PROD_W-1:0] prod_type;

   typedef struct {
      logic [m4i_pkg::IDX_W-1:0]         index;
      logic signed [m4i_pkg::DATA_W-1:0] value;
      logic signed [m4i_pkg::DATA_W-1:0] det;
      logic                              singular;
      logic                              saturated;
      logic                              last;
   } inverse_entry_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [m4i_pkg::IDX_W-1:0] req_entry_index = '0;
   logic signed [m4i_pkg::DATA_W-1:0] req_entry_value = '0;
   logic rsp_valid;
   logic [m4i_pkg::IDX_W-1:0] rsp_out_index;
   logic signed [m4i_pkg::DATA_W-1:0] rsp_out_value;
   logic signed [m4i_pkg::DATA_W-1:0] rsp_determinant;
   logic rsp_singular;
   logic rsp_saturated;
   logic rsp_last;

   logic signed [m4i_pkg::DATA_W-1:0] shadow_matrix [m4i_pkg::CELLS];
   inverse_entry_type pending_inverse [$];
   int mismatches = 0;
   int idle_cycles = 0;
   int burst_left = 0;

   matrix4_inverse_core DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_entry_index(req_entry_index), .req_entry_value(req_entry_value),
      .rsp_valid(rsp_valid), .rsp_out_index(rsp_out_index),
      .rsp_out_value(rsp_out_value), .rsp_determinant(rsp_determinant),
      .rsp_singular(rsp_singular), .rsp_saturated(rsp_saturated),
      .rsp_last(rsp_last)
   );

   always #10 clock = ~clock;

   function automatic wide_type clamp_wide(prod_type v);
      if (v > prod_type'($signed(m4i_pkg::WIDE_MAX))) return $signed(m4i_pkg::WIDE_MAX);
      if (v < prod_type'($signed(m4i_pkg::WIDE_MIN))) return $signed(m4i_pkg::WIDE_MIN);
      return v[m4i_pkg::WIDE_W-1:0];
   endfunction

   function automatic wide_type q_mul(wide_type a, wide_type b);
      prod_type pa, pb, p;
      pa = a;
      pb = b;
      p = pa * pb;
      return clamp_wide(p >>> m4i_pkg::FRAC_BITS);
   endfunction

   function automatic wide_type q_add(wide_type a, wide_type b, bit negate_b);
      prod_type pa, pb;
      pa = a;
      pb = b;
      return negate_b ? clamp_wide(pa - pb) : clamp_wide(pa + pb);
   endfunction

   // Determinant of the matrix with one row and one column removed, or of the
   // whole matrix; permutations are walked in lexicographic order.
   function automatic wide_type minor_det(int skip_r, int skip_c, bit full);
      int rs[4], cs[4], perm[4];
      int n, nc, inv;
      wide_type acc, term;
      bit distinct;
      n = 0; nc = 0; acc = '0;
      for (int k = 0; k < m4i_pkg::MATRIX_DIM; k++) begin
         if (full || k != skip_r) begin rs[n] = k; n++; end
         if (full || k != skip_c) begin cs[nc] = k; nc++; end
      end
      for (int a = 0; a < n; a++)
         for (int b = 0; b < n; b++)
            for (int c = 0; c < n; c++)
               for (int d = 0; d < ((n == 4) ? n : 1); d++) begin
                  perm[0] = a; perm[1] = b; perm[2] = c; perm[3] = d;
                  distinct = 1'b1;
                  inv = 0;
                  for (int x = 0; x < n; x++)
                     for (int y = x + 1; y < n; y++) begin
                        if (perm[x] == perm[y]) distinct = 1'b0;
                        if (perm[x] > perm[y]) inv++;
                     end
                  if (distinct) begin
                     term = wide_type'(shadow_matrix[rs[0]*m4i_pkg::MATRIX_DIM + cs[perm[0]]]);
                     for (int r = 1; r < n; r++)
                        term = q_mul(term, wide_type'(
                           shadow_matrix[rs[r]*m4i_pkg::MATRIX_DIM + cs[perm[r]]]));
                     acc = q_add(acc, term, inv[0]);
                  end
               end
      return acc;
   endfunction

   function automatic logic signed [m4i_pkg::DATA_W-1:0] q_div(wide_type num, wide_type den,
                                                              output logic clip);
      logic [m4i_pkg::PROD_W-1:0] un, ud, q, lim;
      bit neg;
      neg = (num < 0) != (den < 0);
      un = (num < 0) ? m4i_pkg::PROD_W'(-prod_type'(num)) : m4i_pkg::PROD_W'(num);
      ud = (den < 0) ? m4i_pkg::PROD_W'(-prod_type'(den)) : m4i_pkg::PROD_W'(den);
      q = (un << m4i_pkg::FRAC_BITS) / ud;
      lim = neg ? m4i_pkg::PROD_W'(m4i_pkg::DATA_MIN) : m4i_pkg::PROD_W'(m4i_pkg::DATA_MAX);
      clip = q > lim;
      if (clip) return neg ? $signed(m4i_pkg::DATA_MIN) : $signed(m4i_pkg::DATA_MAX);
      return neg ? -$signed(q[m4i_pkg::DATA_W-1:0]) : $signed(q[m4i_pkg::DATA_W-1:0]);
   endfunction

   // Queues the responses that an index-15 transaction produces.
   task automatic predict_inverse();
      wide_type det, m;
      wide_type adj [m4i_pkg::CELLS];
      inverse_entry_type e;
      logic dclip, vclip;
      det = minor_det(0, 0, 1'b1);
      for (int i = 0; i < m4i_pkg::MATRIX_DIM; i++)
         for (int j = 0; j < m4i_pkg::MATRIX_DIM; j++) begin
            m = minor_det(j, i, 1'b0);
            adj[i*m4i_pkg::MATRIX_DIM + j] = ((i + j) % 2) ? q_add('0, m, 1'b1) : m;
         end
      if (det == 0) begin
         e = '{index: '0, value: '0, det: '0, singular: 1'b1, saturated: 1'b0,
               last: 1'b1};
         pending_inverse.push_back(e);
         return;
      end
      dclip = (det > wide_type'($signed(m4i_pkg::DATA_MAX))) ||
              (det < wide_type'($signed(m4i_pkg::DATA_MIN)));
      for (int k = 0; k < m4i_pkg::CELLS; k++) begin
         e.index = m4i_pkg::IDX_W'(k);
         e.value = q_div(adj[k], det, vclip);
         e.det = dclip ? ((det < 0) ? $signed(m4i_pkg::DATA_MIN) : $signed(m4i_pkg::DATA_MAX))
                       : det[m4i_pkg::DATA_W-1:0];
         e.singular = 1'b0;
         e.saturated = vclip || dclip;
         e.last = (k == m4i_pkg::CELLS - 1);
         pending_inverse.push_back(e);
      end
   endtask

   // Sends one entry; the sender sometimes idles between bursts of random length.
   task automatic send_entry(logic [m4i_pkg::IDX_W-1:0] idx,
                             logic signed [m4i_pkg::DATA_W-1:0] val);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 2) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
      end
      burst_left--;
      start <= 1'b1;
      req_entry_index <= idx;
      req_entry_value <= val;
      do @(posedge clock); while (busy);
      shadow_matrix[idx] = val;
      if (idx == LAST_INDEX) predict_inverse();
   endtask

   task automatic wait_quiet();
      start <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_inverse.size() != 0) @(posedge clock);
   endtask

   task automatic load_matrix(logic signed [m4i_pkg::DATA_W-1:0] vals [m4i_pkg::CELLS],
                              bit shuffled);
      int order [m4i_pkg::CELLS-1];
      for (int k = 0; k < m4i_pkg::CELLS - 1; k++) order[k] = k;
      if (shuffled) order.shuffle();
      for (int k = 0; k < m4i_pkg::CELLS - 1; k++)
         send_entry(m4i_pkg::IDX_W'(order[k]), vals[order[k]]);
      send_entry(LAST_INDEX, vals[m4i_pkg::CELLS - 1]);
   endtask

   function automatic logic signed [m4i_pkg::DATA_W-1:0] rand_entry();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return $signed($urandom());
      if (sel == 1) return '0;
      if (sel < 5) return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      return $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
   endfunction

   task automatic test_singular_after_reset();
      send_entry(LAST_INDEX, '0);
      send_entry(LAST_INDEX, $signed(m4i_pkg::DATA_MAX));
   endtask

   task automatic test_identity_and_extremes();
      send_entry(m4i_pkg::IDX_W'(0), 32'sh0001_0000);
      send_entry(m4i_pkg::IDX_W'(5), 32'sh0001_0000);
      send_entry(m4i_pkg::IDX_W'(10), 32'sh0001_0000);
      send_entry(LAST_INDEX, 32'sh0001_0000);
      send_entry(LAST_INDEX, $signed(m4i_pkg::DATA_MAX));
      send_entry(LAST_INDEX, 32'sh0000_0001);
      send_entry(LAST_INDEX, $signed(m4i_pkg::DATA_MIN));
      send_entry(m4i_pkg::IDX_W'(3), -32'sh0000_0001);
      send_entry(m4i_pkg::IDX_W'(0), $signed(m4i_pkg::DATA_MIN));
      send_entry(m4i_pkg::IDX_W'(5), $signed(m4i_pkg::DATA_MIN));
      send_entry(m4i_pkg::IDX_W'(10), $signed(m4i_pkg::DATA_MAX));
      send_entry(LAST_INDEX, $signed(m4i_pkg::DATA_MAX));
      send_entry(m4i_pkg::IDX_W'(12), 32'sh0000_8000);
      send_entry(LAST_INDEX, 32'sh0000_0002);
   endtask

   task automatic test_random_matrices();
      logic signed [m4i_pkg::DATA_W-1:0] vals [m4i_pkg::CELLS];
      for (int m = 0; m < 11; m++) begin
         for (int k = 0; k < m4i_pkg::CELLS; k++) vals[k] = rand_entry();
         // Boost the diagonal on most matrices so the inverse is well formed.
         if ($urandom_range(0, 3) != 0)
            for (int k = 0; k < m4i_pkg::MATRIX_DIM; k++)
               vals[k*5] = vals[k*5] + 32'sh0008_0000;
         load_matrix(vals, 1'($urandom_range(0, 1)));
         if (m == 5) wait_quiet();
      end
   endtask

   task automatic test_loose_entries();
      for (int k = 0; k < 45; k++)
         send_entry(m4i_pkg::IDX_W'($urandom_range(0, m4i_pkg::CELLS - 1)), rand_entry());
      send_entry(LAST_INDEX, $signed($urandom()));
   endtask

   // Response checker: the receiver has no backpressure, so every strobe counts.
   always @(posedge clock) begin
      inverse_entry_type e;
      if (!reset && rsp_valid) begin
         if (pending_inverse.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected response index %0d", rsp_out_index);
         end else begin
            e = pending_inverse.pop_front();
            if (rsp_out_index !== e.index || rsp_out_value !== e.value ||
                rsp_determinant !== e.det || rsp_singular !== e.singular ||
                rsp_saturated !== e.saturated || rsp_last !== e.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"Mismatch: expected idx %0d val %h det %h s%b c%b l%b, ",
                            "got idx %0d val %h det %h s%b c%b l%b"},
                     e.index, e.value, e.det, e.singular, e.saturated, e.last,
                     rsp_out_index, rsp_out_value, rsp_determinant, rsp_singular,
                     rsp_saturated, rsp_last);
            end
         end
      end
   end

   // Watchdog on cycles in which no transaction moves either way.
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      for (int k = 0; k < m4i_pkg::CELLS; k++) shadow_matrix[k] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_singular_after_reset();
      test_identity_and_extremes();
      wait_quiet();
      test_random_matrices();
      test_loose_entries();
      wait_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_inverse.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
